>>> design/opi_pkg.sv
`timescale 1ns / 1ps
// opi_pkg: shared widths, types, register indexes and the factorial table
// for the ordinal pattern index block; depends on nothing
package opi_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int MAX_ORDER    = 8;
    localparam int MAX_SPACING  = 16;
    localparam int WINDOW_DEPTH = (MAX_ORDER - 1) * MAX_SPACING + 1;
    localparam int FILL_WIDTH   = $clog2(WINDOW_DEPTH + 1);
    localparam int ORD_WIDTH    = $clog2(MAX_ORDER);
    localparam int SP_WIDTH     = $clog2(MAX_SPACING);
    localparam int INDEX_WIDTH  = 16;
    localparam int FACT_WIDTH   = 13;
    localparam int CFG_IDX_WIDTH  = 8;
    localparam int CFG_DATA_WIDTH = 5;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [FILL_WIDTH-1:0]          fill_t;
    typedef logic [ORD_WIDTH-1:0]           kmax_t;
    typedef logic [SP_WIDTH-1:0]            spm1_t;
    typedef logic [INDEX_WIDTH-1:0]         index_t;
    typedef logic [FACT_WIDTH-1:0]          fact_t;
    typedef logic [CFG_IDX_WIDTH-1:0]       cfg_index_t;
    typedef logic [CFG_DATA_WIDTH-1:0]      cfg_data_t;

    // register indexes of the configuration port
    localparam cfg_index_t REG_PATTERN_ORDER = 8'd0;
    localparam cfg_index_t REG_SPACING       = 8'd1;

    // reset values, stored as order - 1 and spacing - 1
    localparam kmax_t KMAX_RESET = 3'd6;
    localparam spm1_t SPM1_RESET = 4'd0;

    // n! for n = 0 .. MAX_ORDER-1
    localparam fact_t FACT [MAX_ORDER] = '{
        13'd1, 13'd1, 13'd2, 13'd6, 13'd24, 13'd120, 13'd720, 13'd5040
    };

endpackage

>>> design/opi_delay_line.sv
`timescale 1ns / 1ps
// opi_delay_line: sample shift line, fill count and spacing tap selection
// depends on opi_pkg
module opi_delay_line (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift_en,
    input  logic                new_series,
    input  opi_pkg::sample_t    sample,
    input  opi_pkg::spm1_t      sp_m1,
    input  opi_pkg::fill_t      span,
    output opi_pkg::sample_t    taps [opi_pkg::MAX_ORDER],
    output logic                win_full
);

    opi_pkg::sample_t line_reg [opi_pkg::WINDOW_DEPTH];
    opi_pkg::fill_t   fill_count_reg;
    opi_pkg::fill_t   fill_count_next;
    opi_pkg::fill_t   fill_base;

    // new series restarts the count with the incoming sample
    always_comb
    begin
        fill_base = new_series ? '0 : fill_count_reg;
        if (fill_base < opi_pkg::FILL_WIDTH'(opi_pkg::WINDOW_DEPTH))
        begin
            fill_count_next = fill_base + 1'b1;
        end
        else
        begin
            fill_count_next = fill_base;
        end
        win_full = (fill_count_next >= span);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
        end
        else if (shift_en)
        begin
            fill_count_reg <= fill_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            line_reg[0] <= sample;
            for (int i = 1; i < opi_pkg::WINDOW_DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    // tap k sits k * spacing words back
    always_comb
    begin
        for (int k = 0; k < opi_pkg::MAX_ORDER; k++)
        begin
            taps[k] = line_reg[0];
            for (int s = 0; s < opi_pkg::MAX_SPACING; s++)
            begin
                if (sp_m1 == opi_pkg::SP_WIDTH'(s))
                begin
                    taps[k] = line_reg[k * (s + 1)];
                end
            end
        end
    end

endmodule

>>> design/opi_rank_core.sv
`timescale 1ns / 1ps
// opi_rank_core: pairwise comparator network giving the factorial-base
// pattern index of up to eight taps; depends on opi_pkg
module opi_rank_core (
    input  opi_pkg::sample_t    taps [opi_pkg::MAX_ORDER],
    input  opi_pkg::kmax_t      k_max,
    output opi_pkg::index_t     pattern_index
);

    opi_pkg::kmax_t  rank_c  [opi_pkg::MAX_ORDER];
    opi_pkg::kmax_t  ahead_c [opi_pkg::MAX_ORDER];
    opi_pkg::index_t term_c  [opi_pkg::MAX_ORDER];
    opi_pkg::index_t sum_c;

    // tap k is window element k_max - k; older elements have larger k.
    // rank: older elements not below this one; ahead: elements picked
    // before this one (smaller, or equal and newer)
    always_comb
    begin
        sum_c = '0;
        for (int k = 0; k < opi_pkg::MAX_ORDER; k++)
        begin
            rank_c[k]  = '0;
            ahead_c[k] = '0;
            for (int m = 0; m < opi_pkg::MAX_ORDER; m++)
            begin
                if (m != k && opi_pkg::ORD_WIDTH'(m) <= k_max)
                begin
                    if (m > k && !(taps[m] < taps[k]))
                    begin
                        rank_c[k] = rank_c[k] + 1'b1;
                    end
                    if ((taps[m] < taps[k]) || (taps[m] == taps[k] && m < k))
                    begin
                        ahead_c[k] = ahead_c[k] + 1'b1;
                    end
                end
            end
            term_c[k] = opi_pkg::INDEX_WIDTH'(rank_c[k])
                      * opi_pkg::INDEX_WIDTH'(opi_pkg::FACT[k_max - ahead_c[k]]);
            if (opi_pkg::ORD_WIDTH'(k) <= k_max)
            begin
                sum_c = sum_c + term_c[k];
            end
        end
        pattern_index = sum_c;
    end

endmodule

>>> design/ordinal_pattern_index.sv
`timescale 1ns / 1ps
// ordinal_pattern_index: top level with configuration registers, handshake
// and result register; depends on opi_pkg, opi_delay_line, opi_rank_core
//
// Streaming ordinal pattern index. Each accepted word carries one signed
// sample; a 113-deep shift line keeps the recent history. Once pattern_order
// samples spaced spacing apart are held since the last new_series mark, one
// pattern_index word is produced for that sample, otherwise none. Ties count
// the later sample as smaller. Throughput is one sample per clock while the
// output is not stalled: a sample is taken into the shift line on
// acceptance, the comparator network over the selected taps then feeds the
// result register, which loads as soon as it is free or draining and offers
// the result word from there. The result register and the compute stage let
// the input keep flowing while a result waits; input stalls only when both
// are full and the output is stalled. There is no clearing pass after reset.
// Configuration: index 0 is pattern_order from data bits 3:0 (clamped to
// 2..8), index 1 is spacing (clamped to 1..16), other indexes are ignored;
// cfg_ready is always high and writes are meant for idle periods.
module ordinal_pattern_index (
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  opi_pkg::sample_t        sample,
    input  logic                    new_series,

    output logic                    out_valid,
    input  logic                    out_stall,
    output opi_pkg::index_t         pattern_index,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  opi_pkg::cfg_index_t     cfg_index,
    input  opi_pkg::cfg_data_t      cfg_data
);

    // settings kept as order - 1 and spacing - 1, clamped on write
    opi_pkg::kmax_t   k_max_reg;
    opi_pkg::kmax_t   k_max_next;
    opi_pkg::spm1_t   sp_m1_reg;
    opi_pkg::spm1_t   sp_m1_next;

    logic             calc_valid_reg;
    logic             calc_valid_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    opi_pkg::index_t  index_reg;

    logic             in_accept;
    logic             advance;
    logic             win_full;
    opi_pkg::fill_t   span;
    opi_pkg::sample_t taps [opi_pkg::MAX_ORDER];
    opi_pkg::index_t  core_index;

    assign cfg_ready = 1'b1;

    // register write decode with range clamping
    always_comb
    begin
        k_max_next = k_max_reg;
        sp_m1_next = sp_m1_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                opi_pkg::REG_PATTERN_ORDER:
                begin
                    if (cfg_data[3:0] < 4'd2)
                    begin
                        k_max_next = 3'd1;
                    end
                    else if (cfg_data[3:0] > 4'(opi_pkg::MAX_ORDER))
                    begin
                        k_max_next = opi_pkg::ORD_WIDTH'(opi_pkg::MAX_ORDER - 1);
                    end
                    else
                    begin
                        k_max_next = opi_pkg::ORD_WIDTH'(cfg_data[3:0] - 4'd1);
                    end
                end
                opi_pkg::REG_SPACING:
                begin
                    if (cfg_data == '0)
                    begin
                        sp_m1_next = '0;
                    end
                    else if (cfg_data > 5'(opi_pkg::MAX_SPACING))
                    begin
                        sp_m1_next = opi_pkg::SP_WIDTH'(opi_pkg::MAX_SPACING - 1);
                    end
                    else
                    begin
                        sp_m1_next = opi_pkg::SP_WIDTH'(cfg_data - 5'd1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_max_reg <= opi_pkg::KMAX_RESET;
            sp_m1_reg <= opi_pkg::SPM1_RESET;
        end
        else
        begin
            k_max_reg <= k_max_next;
            sp_m1_reg <= sp_m1_next;
        end
    end

    // samples needed before the first result: (order - 1) * spacing + 1
    assign span = opi_pkg::FILL_WIDTH'(k_max_reg)
                * (opi_pkg::FILL_WIDTH'(sp_m1_reg) + 1'b1) + 1'b1;

    // compute stage moves on when the result register is free or draining
    assign advance   = calc_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = calc_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        calc_valid_next = calc_valid_reg;
        if (in_accept)
        begin
            calc_valid_next = win_full;
        end
        else if (advance)
        begin
            calc_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calc_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            calc_valid_reg <= calc_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result word, loaded as the compute stage hands over
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            index_reg <= core_index;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pattern_index = index_reg;

    // history of samples and the taps picked by the spacing
    opi_delay_line u_delay_line (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (in_accept),
        .new_series (new_series),
        .sample     (sample),
        .sp_m1      (sp_m1_reg),
        .span       (span),
        .taps       (taps),
        .win_full   (win_full)
    );

    // comparator network over the taps of the held window
    opi_rank_core u_rank_core (
        .taps          (taps),
        .k_max         (k_max_reg),
        .pattern_index (core_index)
    );

endmodule

>>> sim/ordinal_pattern_index_tb.sv
`timescale 1ns / 1ps
// ordinal_pattern_index_tb: self-checking bench for the ordinal pattern index block
// depends on opi_pkg and ordinal_pattern_index; predicts every index word and checks it
module ordinal_pattern_index_tb;

    // cycles with no handshake on any channel before the run is abandoned
    localparam int QUIET_LIMIT  = 2000;
    // settle time after the last expected word
    localparam int DRAIN_CYCLES = 6;

    localparam opi_pkg::sample_t SAMPLE_MIN = {1'b1, {(opi_pkg::SAMPLE_WIDTH-1){1'b0}}};
    localparam opi_pkg::sample_t SAMPLE_MAX = ~SAMPLE_MIN;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    opi_pkg::sample_t    sample;
    logic                new_series;
    logic                out_valid;
    logic                out_stall;
    opi_pkg::index_t     pattern_index;
    logic                cfg_valid;
    logic                cfg_ready;
    opi_pkg::cfg_index_t cfg_index;
    opi_pkg::cfg_data_t  cfg_data;

    // idling rates in percent, and the receiver hold-off still to run
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_left      = 0;
    int mismatch_count = 0;

    // predictor state: delay line newest first, fill since the last new series,
    // raw register contents as written
    opi_pkg::sample_t history [opi_pkg::WINDOW_DEPTH];
    int unsigned      filled;
    logic [3:0]       order_reg;
    logic [4:0]       spacing_reg;
    opi_pkg::index_t  expected_index [$];

    ordinal_pattern_index u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .new_series    (new_series),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pattern_index (pattern_index),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // window length after clamping to 2..8
    function automatic int unsigned live_order(input logic [3:0] raw);
        if (raw < 2)
            return 2;
        if (raw > opi_pkg::MAX_ORDER)
            return opi_pkg::MAX_ORDER;
        return raw;
    endfunction

    // element spacing after clamping to 1..16
    function automatic int unsigned live_spacing(input logic [4:0] raw);
        if (raw < 1)
            return 1;
        if (raw > opi_pkg::MAX_SPACING)
            return opi_pkg::MAX_SPACING;
        return raw;
    endfunction

    // factorial-base index of the window: repeatedly pick the smallest value
    // still free, the later one winning a tie, weight its rank among the free
    // elements by (free count - 1)!
    function automatic opi_pkg::index_t ordinal_index(input int unsigned ord,
                                                      input int unsigned sp);
        opi_pkg::sample_t vals [opi_pkg::MAX_ORDER];
        bit               used [opi_pkg::MAX_ORDER];
        int unsigned      weight [opi_pkg::MAX_ORDER];
        int unsigned      acc;
        int unsigned      rank;
        int unsigned      pick;
        int unsigned      seen;
        bit               found;
        opi_pkg::sample_t lowest;
        weight[0] = 1;
        for (int i = 1; i < opi_pkg::MAX_ORDER; i++)
            weight[i] = weight[i-1] * i;
        // element 0 is the oldest, the newest sits at the end
        for (int i = 0; i < ord; i++)
        begin
            vals[i] = history[(ord - 1 - i) * sp];
            used[i] = 1'b0;
        end
        acc = 0;
        for (int j = int'(ord) - 1; j >= 0; j--)
        begin
            found  = 1'b0;
            rank   = 0;
            pick   = 0;
            seen   = 0;
            lowest = '0;
            for (int i = 0; i < ord; i++)
            begin
                if (!used[i])
                begin
                    if (!found || vals[i] <= lowest)
                    begin
                        found  = 1'b1;
                        lowest = vals[i];
                        rank   = seen;
                        pick   = i;
                    end
                    seen++;
                end
            end
            used[pick] = 1'b1;
            acc += rank * weight[j];
        end
        return opi_pkg::index_t'(acc);
    endfunction

    // take one accepted sample into the predictor, queue a word if the window is full
    task automatic take_sample(input opi_pkg::sample_t value, input logic mark);
        int unsigned ord;
        int unsigned sp;
        ord = live_order(order_reg);
        sp  = live_spacing(spacing_reg);
        if (mark)
            filled = 0;
        for (int i = opi_pkg::WINDOW_DEPTH - 1; i > 0; i--)
            history[i] = history[i-1];
        history[0] = value;
        if (filled < opi_pkg::WINDOW_DEPTH)
            filled++;
        if (filled >= (ord - 1) * sp + 1)
            expected_index.push_back(ordinal_index(ord, sp));
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input opi_pkg::index_t got,
                                   input opi_pkg::index_t want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // every accepted result word is held against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_index.size() == 0)
                report_mismatch("unexpected pattern_index word", pattern_index, '0);
            else
            begin
                if (pattern_index !== expected_index[0])
                    report_mismatch("pattern_index", pattern_index, expected_index[0]);
                void'(expected_index.pop_front());
            end
        end
    end

    // receiver: random stall at the current rate, or a counted hold-off when
    // a test asks for one so that the block backs up into its input
    initial
    begin : receiver
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog: any handshake restarts the count, a long silence ends the run
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet = quiet + 1;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // offer one sample word after a random gap, hold it until taken, then predict
    task automatic send_word(input opi_pkg::sample_t value, input logic mark);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        sample     <= value;
        new_series <= mark;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        take_sample(value, mark);
    endtask

    // drop valid, wait for every expected word, then let the pipeline settle
    // so that a last sample with no result has also left the block
    task automatic drain_block();
        in_valid <= 1'b0;
        while (expected_index.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write both registers, optionally followed by a write to an unused index;
    // only called with the block idle
    task automatic apply_settings(input opi_pkg::cfg_data_t order_val,
                                  input opi_pkg::cfg_data_t spacing_val,
                                  input bit add_stray,
                                  input opi_pkg::cfg_index_t stray_index);
        opi_pkg::cfg_index_t idx [3];
        opi_pkg::cfg_data_t  val [3];
        int                  count;
        idx[0] = opi_pkg::REG_PATTERN_ORDER;
        val[0] = order_val;
        idx[1] = opi_pkg::REG_SPACING;
        val[1] = spacing_val;
        idx[2] = stray_index;
        val[2] = opi_pkg::cfg_data_t'($urandom);
        count  = add_stray ? 3 : 2;
        for (int k = 0; k < count; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            if (idx[k] == opi_pkg::REG_PATTERN_ORDER)
                order_reg = val[k][3:0];
            else if (idx[k] == opi_pkg::REG_SPACING)
                spacing_reg = val[k];
        end
        cfg_valid <= 1'b0;
    endtask

    // sample mix: full range, a narrow band that makes ties, and the extremes
    function automatic opi_pkg::sample_t rand_sample();
        case ($urandom_range(9))
            0, 1, 2, 3: return opi_pkg::sample_t'($urandom);
            4, 5, 6:    return opi_pkg::sample_t'(int'($urandom_range(8)) - 4);
            7:
            begin
                case ($urandom_range(3))
                    0:       return SAMPLE_MIN;
                    1:       return SAMPLE_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            8:       return SAMPLE_MIN + opi_pkg::sample_t'($urandom_range(3));
            default: return SAMPLE_MAX - opi_pkg::sample_t'($urandom_range(3));
        endcase
    endfunction

    // one series: new-series mark on the first word if fresh, then len - 1 more words
    task automatic send_series(input int len, input logic fresh);
        for (int k = 0; k < len; k++)
            send_word(rand_sample(), (k == 0) ? fresh : ($urandom_range(199) == 0));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset settings (order 7, spacing 1): field extremes, a tied window,
    // a new-series mark in mid-stream, a series too short to give a word
    task automatic test_directed_window();
        opi_pkg::sample_t values [22];
        values = '{SAMPLE_MIN, SAMPLE_MAX, 32'sd0, -32'sd1, 32'sd1, SAMPLE_MIN + 32'sd1,
                   SAMPLE_MAX - 32'sd1, 32'sd100, 32'sd200, 32'sd300,
                   32'sd5, 32'sd5, 32'sd5, 32'sd5, 32'sd5, 32'sd5, 32'sd5,
                   32'sd4, 32'sd3, 32'sd2, SAMPLE_MAX, SAMPLE_MIN};
        for (int k = 0; k < 22; k++)
            send_word(values[k], (k == 0) || (k == 10) || (k == 20));
        drain_block();
    endtask

    // register extremes and out-of-range values that must clamp, writes to
    // unused indexes, and a settings change in the middle of a series
    task automatic test_register_limits();
        opi_pkg::cfg_data_t  ord_list [6];
        opi_pkg::cfg_data_t  sp_list  [6];
        opi_pkg::cfg_index_t stray_list [6];
        int                  span;
        ord_list   = '{5'd0, 5'd1, 5'd9, 5'd31, 5'd8, 5'd2};
        sp_list    = '{5'd0, 5'd17, 5'd31, 5'd1, 5'd16, 5'd1};
        stray_list = '{8'd2, 8'd255, 8'd3, 8'd128, 8'd127, 8'd255};
        for (int k = 0; k < 6; k++)
        begin
            apply_settings(ord_list[k], sp_list[k], 1'b1, stray_list[k]);
            span = (live_order(order_reg) - 1) * live_spacing(spacing_reg) + 1;
            send_series(span + $urandom_range(3, 12), 1'b1);
            drain_block();
        end
        // history kept across the change, new settings from the next word
        apply_settings(5'd5, 5'd3, 1'b0, '0);
        send_series(20, 1'b0);
        drain_block();
    endtask

    // receiver holds off for a long stretch while the sender keeps offering,
    // so the result stage fills and the input has to stall
    task automatic test_stall_pressure();
        int saved_pct;
        saved_pct = send_idle_pct;
        apply_settings(5'd3, 5'd1, 1'b0, '0);
        send_idle_pct = 0;
        hold_left     = 150;
        send_series(40, 1'b1);
        drain_block();
        send_idle_pct = saved_pct;
    endtask

    // random settings, mostly full series with random content, some cut short,
    // some carried across a settings change without a new-series mark
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int item_goal);
        int                 sent;
        int                 span;
        int                 len;
        opi_pkg::cfg_data_t ord_val;
        opi_pkg::cfg_data_t sp_val;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < item_goal)
        begin
            drain_block();
            case ($urandom_range(9))
                0:       ord_val = opi_pkg::cfg_data_t'($urandom_range(31));
                1:       ord_val = ($urandom_range(1) != 0) ? 5'd2 : 5'd8;
                default: ord_val = opi_pkg::cfg_data_t'($urandom_range(2, 8));
            endcase
            case ($urandom_range(9))
                0:       sp_val = opi_pkg::cfg_data_t'($urandom_range(31));
                1:       sp_val = 5'd16;
                2, 3:    sp_val = opi_pkg::cfg_data_t'($urandom_range(1, 16));
                default: sp_val = opi_pkg::cfg_data_t'($urandom_range(1, 3));
            endcase
            apply_settings(ord_val, sp_val, ($urandom_range(7) == 0),
                           opi_pkg::cfg_index_t'($urandom_range(2, 255)));
            span = (live_order(order_reg) - 1) * live_spacing(spacing_reg) + 1;
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(4) == 0)
                    len = $urandom_range(1, span);
                else
                    len = span + $urandom_range(0, 30);
                send_series(len, ($urandom_range(3) != 0));
                sent += len;
            end
        end
        drain_block();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        in_valid   <= 1'b0;
        sample     <= '0;
        new_series <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        rst_n      <= 1'b0;
        // predictor mirrors the reset settings
        order_reg     = 4'd7;
        spacing_reg   = 5'd1;
        filled        = 0;
        send_idle_pct = 16;
        recv_idle_pct = 48;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_window();
        test_register_limits();
        test_stall_pressure();
        // sender light and receiver heavy, then swapped, then no idling at all
        test_random_traffic(16, 48, 280);
        test_random_traffic(48, 16, 280);
        test_random_traffic(0, 0, 280);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
